// ===== src/draw_histogram_pair_counter_unit_defines.svh =====
// Assertion macros used by the draw histogram datapath.
`ifndef DRAW_HISTOGRAM_PAIR_COUNTER_UNIT_DEFINES_SVH
`define DRAW_HISTOGRAM_PAIR_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DHPC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DHPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dhpc_pkg.sv =====
package dhpc_pkg;

  // Field and store geometry.
  localparam int VAL_W      = 6;
  localparam int SLOTS      = 2 ** VAL_W;
  localparam int PAIR_AW    = 2 * VAL_W;
  localparam int PAIR_DEPTH = 2 ** PAIR_AW;
  localparam int OUT_W      = 16;
  localparam int MAX_PICK   = 6;
  localparam int IDX_W      = 3;

  // Default configuration.
  localparam int POOL_DEF       = 60;
  localparam int PICK_DEF       = 6;
  localparam int COUNT_BITS_DEF = 16;

  // Operation codes.
  typedef logic [1:0] func_t;
  localparam func_t FN_ADD       = 2'd0;
  localparam func_t FN_READ_VAL  = 2'd1;
  localparam func_t FN_READ_PAIR = 2'd2;
  localparam func_t FN_CLEAR     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic iter_init;
    logic add_step;
    logic total_inc;
    logic read_issue;
    logic clear_state;
    logic sweep;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  req_valid;
    logic  item_bad;
    logic  iter_last;
    logic  sweep_last;
    logic  out_busy;
  } sta_t;

endpackage

// ===== src/dhpc_if.sv =====
// Request channel: one operation per beat.
interface dhpc_req_if import dhpc_pkg::*; ();
  logic             valid;
  logic             ready;
  func_t            func;
  logic [VAL_W-1:0] val0;
  logic [VAL_W-1:0] val1;
  logic [VAL_W-1:0] val2;
  logic [VAL_W-1:0] val3;
  logic [VAL_W-1:0] val4;
  logic [VAL_W-1:0] val5;

  modport source (output valid, func, val0, val1, val2, val3, val4, val5, input ready);
  modport sink (input valid, func, val0, val1, val2, val3, val4, val5, output ready);
endinterface

// Response channel: one result per beat.
interface dhpc_rsp_if import dhpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] hit_count;
  logic [OUT_W-1:0] draws_since;
  logic             never_seen;
  logic             status;

  modport source (output valid, hit_count, draws_since, never_seen, status, input ready);
  modport sink (input valid, hit_count, draws_since, never_seen, status, output ready);
endinterface

// ===== src/dhpc_ctrl.sv =====
module dhpc_ctrl import dhpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sta_t sta,
  output cmd_t cmd
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sta.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sta.req_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sta.item_bad) begin
          state_next = S_RESP;
        end else begin
          unique case (sta.func) inside
            FN_ADD: begin
              cmd.iter_init = 1'b1;
              state_next    = S_ADD;
            end
            FN_READ_VAL, FN_READ_PAIR: begin
              cmd.read_issue = 1'b1;
              state_next     = S_RESP;
            end
            FN_CLEAR: begin
              cmd.clear_state = 1'b1;
              state_next      = S_RESP;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (sta.iter_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.total_inc = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (!sta.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = (sta.func == FN_CLEAR) ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register; reset starts with a sweep of the pair memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/dhpc_datapath.sv =====
module dhpc_datapath import dhpc_pkg::*; #(
  parameter int POOL       = POOL_DEF,
  parameter int PICK       = PICK_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sta_t        sta,
  dhpc_req_if.sink    req,
  dhpc_rsp_if.source  rsp
);

  `include "draw_histogram_pair_counter_unit_defines.svh"

  localparam int CW     = (COUNT_BITS > OUT_W) ? OUT_W : COUNT_BITS;
  localparam int NPAIR  = PICK * (PICK - 1) / 2;
  localparam int NSTEP  = (NPAIR > PICK) ? NPAIR : PICK;
  localparam int STEP_W = $clog2(NSTEP + 1);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic in_pool(input logic [VAL_W-1:0] v);
    return (v != '0) && (v <= VAL_W'(POOL));
  endfunction

  // Pair entries are symmetric, so only the ordered (low, high) entry is kept.
  function automatic logic [PAIR_AW-1:0] pair_addr(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
    return (a < b) ? {a, b} : {b, a};
  endfunction

  // Captured request.
  func_t            func_q;
  logic [VAL_W-1:0] item_v [MAX_PICK];

  // Shift lines that walk the values and the pairs of a draw.
  logic [VAL_W-1:0] oq [MAX_PICK];
  logic [VAL_W-1:0] bq [MAX_PICK-1];
  logic [VAL_W-1:0] vq [MAX_PICK];
  logic [IDX_W-1:0] ilen;
  logic [IDX_W-1:0] ileft;
  logic [STEP_W-1:0] step;

  // Stores.
  logic [CW-1:0]    pmem [PAIR_DEPTH];
  logic [2*CW-1:0]  vmem [SLOTS];
  logic [SLOTS-1:0] vvalid;
  logic [CW-1:0]    total;
  logic [PAIR_AW-1:0] sweep_cnt;

  // Read data and write-back pipeline.
  logic [CW-1:0]      prd;
  logic [2*CW-1:0]    vrd;
  logic               vvalid_q;
  logic               pwr_pend;
  logic [PAIR_AW-1:0] pwr_addr;
  logic               vwr_pend;
  logic [VAL_W-1:0]   vwr_addr;

  // Response registers.
  logic             rsp_valid;
  logic [OUT_W-1:0] out_hit;
  logic [OUT_W-1:0] out_since;
  logic             out_never;
  logic             out_status;

  logic               accept;
  logic               item_bad;
  logic               pair_issue;
  logic               val_issue;
  logic [PAIR_AW-1:0] pra;
  logic               pre;
  logic               pwe;
  logic [PAIR_AW-1:0] pwa;
  logic [CW-1:0]      pwd;
  logic [VAL_W-1:0]   vra;
  logic               vre;
  logic [CW-1:0]      vcnt_old;
  logic [CW-1:0]      vcount;
  logic [CW-1:0]      vlast;
  logic [CW-1:0]      since_raw;
  logic [OUT_W-1:0]   res_hit;
  logic [OUT_W-1:0]   res_since;
  logic               res_never;
  logic               res_status;

  assign accept    = req.valid && req.ready;
  assign req.ready = cmd.take;

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= req.func;
      item_v[0] <= req.val0;
      item_v[1] <= req.val1;
      item_v[2] <= req.val2;
      item_v[3] <= req.val3;
      item_v[4] <= req.val4;
      item_v[5] <= req.val5;
    end
  end

  // Range and duplicate checks on the captured request.
  always_comb begin
    logic bad_draw;
    bad_draw = 1'b0;
    for (int i = 0; i < PICK; i++) begin
      if (!in_pool(item_v[i])) begin
        bad_draw = 1'b1;
      end
      for (int j = 0; j < i; j++) begin
        if (item_v[i] == item_v[j]) begin
          bad_draw = 1'b1;
        end
      end
    end
    case (func_q)
      FN_ADD:       item_bad = bad_draw;
      FN_READ_VAL:  item_bad = !in_pool(item_v[0]);
      FN_READ_PAIR: item_bad = !in_pool(item_v[0]) || !in_pool(item_v[1]) ||
                               (item_v[0] == item_v[1]);
      default:      item_bad = 1'b0;
    endcase
  end

  // Walk of the draw: each step issues the next pair while pairs remain and the next value while values remain.
  assign pair_issue = cmd.add_step && (step < STEP_W'(NPAIR));
  assign val_issue  = cmd.add_step && (step < STEP_W'(PICK));

  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      step  <= '0;
      ilen  <= IDX_W'(PICK - 1);
      ileft <= IDX_W'(PICK - 1);
      for (int k = 0; k < MAX_PICK; k++) begin
        oq[k] <= item_v[k];
        vq[k] <= item_v[k];
      end
      for (int k = 0; k < MAX_PICK - 1; k++) begin
        bq[k] <= item_v[k+1];
      end
    end else if (cmd.add_step) begin
      step <= step + 1'b1;
      for (int k = 0; k < MAX_PICK - 1; k++) begin
        vq[k] <= vq[k+1];
      end
      vq[MAX_PICK-1] <= '0;
      if (ileft == IDX_W'(1)) begin
        // Inner run done: the next value becomes the first of the pair.
        for (int k = 0; k < MAX_PICK - 1; k++) begin
          oq[k] <= oq[k+1];
        end
        oq[MAX_PICK-1] <= '0;
        for (int k = 0; k < MAX_PICK - 2; k++) begin
          bq[k] <= oq[k+2];
        end
        bq[MAX_PICK-2] <= '0;
        ilen  <= ilen - 1'b1;
        ileft <= ilen - 1'b1;
      end else begin
        for (int k = 0; k < MAX_PICK - 2; k++) begin
          bq[k] <= bq[k+1];
        end
        bq[MAX_PICK-2] <= '0;
        ileft <= ileft - 1'b1;
      end
    end
  end

  // Pair memory ports.
  assign pra = pair_issue ? pair_addr(oq[0], bq[0]) : pair_addr(item_v[0], item_v[1]);
  assign pre = pair_issue || cmd.read_issue;
  assign pwe = cmd.sweep || pwr_pend;
  assign pwa = cmd.sweep ? sweep_cnt : pwr_addr;
  assign pwd = cmd.sweep ? '0 : sat_inc(prd);

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    if (pre) begin
      prd <= pmem[pra];
    end
  end

  // Value memory ports; an entry without its valid bit reads as zero.
  assign vra      = val_issue ? vq[0] : item_v[0];
  assign vre      = val_issue || cmd.read_issue;
  assign vcount   = vrd[CW-1:0];
  assign vlast    = vrd[2*CW-1:CW];
  assign vcnt_old = vvalid_q ? vcount : '0;

  always_ff @(posedge clk) begin
    if (vwr_pend) begin
      vmem[vwr_addr] <= {total, sat_inc(vcnt_old)};
    end
    if (vre) begin
      vrd      <= vmem[vra];
      vvalid_q <= vvalid[vra];
    end
  end

  // Write-back addresses are registered from their reads and used in the next cycle.
  always_ff @(posedge clk) begin
    pwr_addr <= pra;
    vwr_addr <= vra;
    if (rst) begin
      pwr_pend <= 1'b0;
      vwr_pend <= 1'b0;
    end else begin
      pwr_pend <= pair_issue;
      vwr_pend <= val_issue;
    end
  end

  // Valid bits double as the seen flags; total counts accepted draws.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_state) begin
      vvalid <= '0;
      total  <= '0;
    end else begin
      if (vwr_pend) begin
        vvalid[vwr_addr] <= 1'b1;
      end
      if (cmd.total_inc) begin
        total <= sat_inc(total);
      end
    end
  end

  // Sweep address for clearing the pair memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // Result assembly.
  assign since_raw = total - vlast - 1'b1;

  always_comb begin
    res_hit    = '0;
    res_since  = '0;
    res_never  = 1'b0;
    res_status = 1'b0;
    case (func_q)
      FN_ADD: begin
        res_status = item_bad;
      end
      FN_READ_VAL: begin
        if (item_bad) begin
          res_status = 1'b1;
        end else begin
          res_hit   = OUT_W'(vcnt_old);
          res_never = !vvalid_q;
          if (vvalid_q && (total > vlast)) begin
            res_since = OUT_W'(since_raw);
          end
        end
      end
      FN_READ_PAIR: begin
        if (item_bad) begin
          res_status = 1'b1;
        end else begin
          res_hit = OUT_W'(prd);
        end
      end
      default: begin
        res_status = 1'b0;
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_hit    <= res_hit;
      out_since  <= res_since;
      out_never  <= res_never;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.hit_count   = out_hit;
  assign rsp.draws_since = out_since;
  assign rsp.never_seen  = out_never;
  assign rsp.status      = out_status;

  // Status to the controller.
  assign sta.func       = func_q;
  assign sta.req_valid  = req.valid;
  assign sta.item_bad   = item_bad;
  assign sta.iter_last  = (step == STEP_W'(NSTEP - 1));
  assign sta.sweep_last = &sweep_cnt;
  assign sta.out_busy   = rsp_valid && !rsp.ready;

  // A new result never replaces one that has not been taken.
  `DHPC_ASSERT_IMP(a_no_overrun, clk, rst, cmd.load_result, !(rsp_valid && !rsp.ready), "result overwritten before taken")
  // The clearing sweep never overlaps a pending write-back.
  `DHPC_ASSERT_IMP(a_sweep_alone, clk, rst, cmd.sweep, !pwr_pend && !vwr_pend, "sweep overlaps a write-back")
  // A value write marks its entry as seen.
  `DHPC_ASSERT_NEXT(a_seen_set, clk, rst, vwr_pend && !cmd.clear_state, vvalid[$past(vwr_addr)], "seen flag not set after value write")
  // A never-seen value reports no draws since.
  `DHPC_ASSERT_IMP(a_never_since, clk, rst, rsp_valid && out_never, out_since == '0, "draws since nonzero for a never-seen value")

endmodule

// ===== src/draw_histogram_pair_counter_unit.sv =====
// Draw histogram with pair co-occurrence counts. Each request beat carries one
// operation: add a draw of PICK distinct values from 1 to POOL, read a value's
// count, draws-since and never-seen flag, read the count of an unordered pair,
// or clear all stores; every request gives exactly one response beat, and a bad
// value or duplicate sets status and changes nothing. Counters saturate at
// min(2^COUNT_BITS - 1, 65535). An add walks its values and pairs through the
// value and pair memories; the pair memory takes one pipelined read-modify-write
// per cycle. After reset, and after each clear, the block runs a sweep that
// zeroes all 4096 entries of the pair memory and accepts no request meanwhile.
module draw_histogram_pair_counter_unit import dhpc_pkg::*; #(
  parameter int POOL       = POOL_DEF,
  parameter int PICK       = PICK_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dhpc_req_if.sink   req,
  dhpc_rsp_if.source rsp
);

  cmd_t cmd;
  sta_t sta;

  // Sequencer for adds, reads, clears and the clearing sweep.
  dhpc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sta (sta),
    .cmd (cmd)
  );

  // Stores, checks and response register.
  dhpc_datapath #(
    .POOL       (POOL),
    .PICK       (PICK),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sta (sta),
    .req (req),
    .rsp (rsp)
  );

endmodule
